FILE: rtl/core/fix_message_deframer_assert.svh
// Assertion macros for the deframer checker.
// Each macro takes a label, clock, active-low reset, antecedent,
// consequent and a message string.
`ifndef FIX_MESSAGE_DEFRAMER_ASSERT_SVH
`define FIX_MESSAGE_DEFRAMER_ASSERT_SVH

// Same-cycle implication
`define FMD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FMD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/fmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fmd_pkg;

    localparam int LENGTH_BITS_DEFAULT = 16;
    localparam int TDATA_W = 40;
    localparam int TUSER_W = 4;

    localparam logic [7:0] SOH_BYTE   = 8'h01;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_1     = 8'h31;
    localparam logic [7:0] CHAR_8     = 8'h38;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_F     = 8'h46;
    localparam logic [7:0] CHAR_I     = 8'h49;
    localparam logic [7:0] CHAR_X     = 8'h58;

    localparam logic [2:0] MARKER_LEN  = 3'd5;
    localparam logic [2:0] TAG_LEN     = 3'd3;
    localparam logic [2:0] TRAILER_END = 3'd6;

    // Sum of "8=FIX" modulo 256
    localparam logic [7:0] MARKER_SUM = CHAR_8 + CHAR_EQ + CHAR_F + CHAR_I + CHAR_X;

    localparam logic [7:0] MAX_LEN_RESET = 8'hFF;

    // Region tags
    localparam logic [2:0] RG_OUT   = 3'd0;
    localparam logic [2:0] RG_BEGIN = 3'd1;
    localparam logic [2:0] RG_LEN   = 3'd2;
    localparam logic [2:0] RG_BODY  = 3'd3;
    localparam logic [2:0] RG_TRAIL = 3'd4;

    // Status codes
    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_GOOD = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_FMT  = 2'd3;

    typedef enum logic [6:0] {
        PH_HUNT  = 7'b0000001,
        PH_BEGIN = 7'b0000010,
        PH_TAG   = 7'b0000100,
        PH_EQ    = 7'b0001000,
        PH_LEN   = 7'b0010000,
        PH_BODY  = 7'b0100000,
        PH_TRAIL = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        start_flag;
        logic [2:0]  region;
        logic        end_flag;
        logic [1:0]  status;
        logic [15:0] msg_len;
        logic [7:0]  computed_sum;
    } result_t;

    function automatic logic [7:0] marker_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CHAR_8;
            3'd1:    c = CHAR_EQ;
            3'd2:    c = CHAR_F;
            3'd3:    c = CHAR_I;
            default: c = CHAR_X;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] trailer_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = CHAR_1;
            2'd1:    c = CHAR_0;
            default: c = CHAR_EQ;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fmd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module fmd_parser #(
    parameter int LENGTH_BITS = fmd_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      data_byte,
    input  wire logic [15:0]     max_body_length,
    output fmd_pkg::result_t     result
);
    import fmd_pkg::*;

    localparam int LW = LENGTH_BITS + 4;
    localparam int CW = (LW > 16) ? LW : 16;

    phase_t                 phase_reg, phase_next;
    logic [2:0]             marker_idx_reg, marker_idx_next;
    logic                   have_digit_reg, have_digit_next;
    logic [LENGTH_BITS-1:0] len_acc_reg, len_acc_next;
    logic [LENGTH_BITS-1:0] remain_reg, remain_next;
    logic [7:0]             sum_reg, sum_next;
    logic [2:0]             trail_idx_reg, trail_idx_next;
    logic [9:0]             rx_sum_reg, rx_sum_next;

    logic                   err;
    logic                   is_digit;
    logic [7:0]             sum_add;
    logic [2:0]             hunt_idx;
    logic [LW-1:0]          len_candidate;
    logic                   too_big;
    logic [LENGTH_BITS-1:0] remain_dec;
    logic [LENGTH_BITS+15:0] len_wide;

    // Helpers for the phase logic, some shared by several phases
    always_comb
    begin
        is_digit      = (data_byte >= CHAR_0) && (data_byte <= CHAR_9);
        sum_add       = sum_reg + data_byte;
        hunt_idx      = (marker_idx_reg >= MARKER_LEN) ? 3'd0 : marker_idx_reg;
        len_candidate = (LW'(len_acc_reg) << 3) + (LW'(len_acc_reg) << 1)
                        + LW'(data_byte[3:0]);
        too_big       = (CW'(len_candidate) > CW'(max_body_length))
                        || (len_candidate[LW-1:LENGTH_BITS] != '0);
        remain_dec    = (remain_reg == '0) ? '0 : remain_reg - 1'b1;
    end

    // Next state and result for the current byte
    always_comb
    begin
        phase_next      = phase_reg;
        marker_idx_next = marker_idx_reg;
        have_digit_next = have_digit_reg;
        len_acc_next    = len_acc_reg;
        remain_next     = remain_reg;
        sum_next        = sum_reg;
        trail_idx_next  = trail_idx_reg;
        rx_sum_next     = rx_sum_reg;
        err             = 1'b0;
        result          = '0;
        result.out_byte = data_byte;
        result.status   = ST_BUSY;
        result.region   = RG_OUT;

        unique case (phase_reg)
            PH_BEGIN:
            begin
                result.region = RG_BEGIN;
                sum_next      = sum_add;
                if (data_byte == SOH_BYTE)
                begin
                    phase_next = PH_TAG;
                end
            end
            PH_TAG:
            begin
                result.region = RG_LEN;
                sum_next      = sum_add;
                if (data_byte != CHAR_9)
                begin
                    err = 1'b1;
                end
                else
                begin
                    phase_next = PH_EQ;
                end
            end
            PH_EQ:
            begin
                result.region = RG_LEN;
                sum_next      = sum_add;
                if (data_byte != CHAR_EQ)
                begin
                    err = 1'b1;
                end
                else
                begin
                    phase_next      = PH_LEN;
                    len_acc_next    = '0;
                    have_digit_next = 1'b0;
                end
            end
            PH_LEN:
            begin
                result.region = RG_LEN;
                sum_next      = sum_add;
                if (data_byte == SOH_BYTE)
                begin
                    if (!have_digit_reg)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        have_digit_next = 1'b0;
                        remain_next     = len_acc_reg;
                        if (len_acc_reg == '0)
                        begin
                            phase_next     = PH_TRAIL;
                            trail_idx_next = '0;
                            rx_sum_next    = '0;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                end
                else if (is_digit && !too_big)
                begin
                    len_acc_next    = len_candidate[LENGTH_BITS-1:0];
                    have_digit_next = 1'b1;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            PH_BODY:
            begin
                result.region = RG_BODY;
                sum_next      = sum_add;
                remain_next   = remain_dec;
                if (remain_dec == '0)
                begin
                    phase_next     = PH_TRAIL;
                    trail_idx_next = '0;
                    rx_sum_next    = '0;
                end
            end
            PH_TRAIL:
            begin
                result.region = RG_TRAIL;
                if (trail_idx_reg < TAG_LEN)
                begin
                    if (data_byte != trailer_char(trail_idx_reg[1:0]))
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        trail_idx_next = trail_idx_reg + 3'd1;
                    end
                end
                else if (trail_idx_reg < TRAILER_END)
                begin
                    if (!is_digit)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        rx_sum_next    = (rx_sum_reg << 3) + (rx_sum_reg << 1)
                                         + 10'(data_byte[3:0]);
                        trail_idx_next = trail_idx_reg + 3'd1;
                    end
                end
                else
                begin
                    // closing byte, whatever its value
                    result.end_flag = 1'b1;
                    result.status   = (rx_sum_reg == 10'(sum_reg)) ? ST_GOOD : ST_BAD;
                    phase_next      = PH_HUNT;
                    marker_idx_next = '0;
                    trail_idx_next  = '0;
                end
            end
            default:
            begin
                // hunting; an unknown phase code hunts as well
                phase_next = PH_HUNT;
                if (data_byte == marker_char(hunt_idx))
                begin
                    if (hunt_idx == MARKER_LEN - 3'd1)
                    begin
                        result.start_flag = 1'b1;
                        result.region     = RG_BEGIN;
                        phase_next        = PH_BEGIN;
                        sum_next          = MARKER_SUM;
                        len_acc_next      = '0;
                        marker_idx_next   = '0;
                    end
                    else
                    begin
                        marker_idx_next = hunt_idx + 3'd1;
                    end
                end
                else
                begin
                    marker_idx_next = (data_byte == CHAR_8) ? 3'd1 : 3'd0;
                end
            end
        endcase

        // Format error: abort, an offending '8' starts a new marker
        if (err)
        begin
            result.end_flag = 1'b1;
            result.status   = ST_FMT;
            phase_next      = PH_HUNT;
            marker_idx_next = (data_byte == CHAR_8) ? 3'd1 : 3'd0;
            trail_idx_next  = '0;
        end

        len_wide = (LENGTH_BITS + 16)'(len_acc_next);
        if (result.end_flag)
        begin
            result.msg_len      = len_wide[15:0];
            result.computed_sum = sum_next;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            marker_idx_reg <= '0;
            have_digit_reg <= 1'b0;
            len_acc_reg    <= '0;
            remain_reg     <= '0;
            sum_reg        <= '0;
            trail_idx_reg  <= '0;
            rx_sum_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            marker_idx_reg <= marker_idx_next;
            have_digit_reg <= have_digit_next;
            len_acc_reg    <= len_acc_next;
            remain_reg     <= remain_next;
            sum_reg        <= sum_next;
            trail_idx_reg  <= trail_idx_next;
            rx_sum_reg     <= rx_sum_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/fix_message_deframer.sv
// FIX message deframer. Takes one stream byte per clock unless stalled and
// returns one tagged item per byte: the byte, its message region, a start
// flag on the byte completing "8=FIX", and on the last trailer byte (or a
// byte that breaks the format) tlast with the status, the parsed body length
// and the byte sum modulo 256 of everything before "10=". Throughput is one
// item every cycle while the output is not held; a byte passes the input
// register, then the parser state update into the output register. The input
// stalls once its register is full and the output is held. max_body_length
// (reset 65535) is written through the cfg channel, always ready; the user
// must write it only while no item is in flight, the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module fix_message_deframer #(
    parameter int LENGTH_BITS = fmd_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // input bytes
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] data_byte
    // tagged output items
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [7:0] out_byte, [9:8] status, [25:10] msg_len, [33:26] computed_sum
    output logic [fmd_pkg::TDATA_W-1:0]      m_tdata,
    output logic [fmd_pkg::TUSER_W-1:0]      m_tuser,   // [0] start_flag, [3:1] region
    output logic                             m_tlast,   // end_flag
    // configuration
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [15:0]                 cfg_data   // max_body_length
);
    import fmd_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic [15:0] max_len_reg;
    logic        advance;
    logic        step;
    result_t     result;

    // Both registers move when the output is free; the input register also loads while empty
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign step      = in_valid_reg && advance;
    assign cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= {MAX_LEN_RESET, MAX_LEN_RESET};
        end
        else if (cfg_valid)
        begin
            max_len_reg <= cfg_data;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (step)
        begin
            out_reg <= result;
        end
    end

    fmd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .data_byte       (in_byte_reg),
        .max_body_length (max_len_reg),
        .result          (result)
    );

    // Output packing
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.end_flag;
    assign m_tuser  = {out_reg.region, out_reg.start_flag};
    assign m_tdata  = TDATA_W'({out_reg.computed_sum, out_reg.msg_len,
                                out_reg.status, out_reg.out_byte});

endmodule

`default_nettype wire

FILE: rtl/core/fmd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "fix_message_deframer_assert.svh"

module fmd_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    input  wire logic                        s_tready,
    input  wire logic [7:0]                  s_tdata,
    input  wire logic                        m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic [fmd_pkg::TDATA_W-1:0] m_tdata,
    input  wire logic [fmd_pkg::TUSER_W-1:0] m_tuser,
    input  wire logic                        m_tlast,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_ready,
    input  wire logic [15:0]                 cfg_data
);
    import fmd_pkg::*;

    logic unused_ok;
    assign unused_ok = s_tvalid ^ s_tready ^ (^s_tdata) ^ cfg_valid ^ cfg_ready ^ (^cfg_data);

    // A closing item always carries a final status
    `FMD_ASSERT_IMP(a_last_has_status, clk, rst_n, m_tvalid && m_tlast,
        m_tdata[9:8] != ST_BUSY, "tlast item with in-progress status")

    // Items inside a message report nothing but the byte
    `FMD_ASSERT_IMP(a_mid_clean, clk, rst_n, m_tvalid && !m_tlast,
        m_tdata[9:8] == ST_BUSY && m_tdata[33:10] == '0, "non-final item carries results")

    // The marker byte opens the begin string region
    `FMD_ASSERT_IMP(a_start_region, clk, rst_n, m_tvalid && m_tuser[0],
        m_tuser[3:1] == RG_BEGIN && !m_tlast, "start flag outside begin string")

    // A stalled output item holds
    `FMD_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "stalled output item changed")

endmodule

bind fix_message_deframer fmd_checker u_fmd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);

`default_nettype wire

FILE: bench/tb_fix_message_deframer.sv
`timescale 1ns / 1ps

module tb_fix_message_deframer;

    import fmd_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 10;

    // Mirrors the deframer state per accepted byte and keeps the tagged items it should emit
    class deframer_scoreboard;
        result_t     expected_items[$];
        int          error_count;
        logic [15:0] max_len;
        phase_t      phase;
        int          marker_pos;
        bit          have_digit;
        logic [15:0] len_acc;
        logic [15:0] body_left;
        logic [7:0]  run_sum;
        int          trail_pos;
        logic [9:0]  rx_sum;
        logic [7:0]  marker_text [5];
        logic [7:0]  trailer_text [3];

        function new();
            error_count  = 0;
            max_len      = 16'hFFFF;
            phase        = PH_HUNT;
            marker_pos   = 0;
            have_digit   = 1'b0;
            len_acc      = '0;
            body_left    = '0;
            run_sum      = '0;
            trail_pos    = 0;
            rx_sum       = '0;
            marker_text  = '{CHAR_8, CHAR_EQ, CHAR_F, CHAR_I, CHAR_X};
            trailer_text = '{CHAR_1, CHAR_0, CHAR_EQ};
        endfunction

        function void set_max_len(logic [15:0] v);
            max_len = v;
        endfunction

        function int pending();
            return expected_items.size();
        endfunction

        function bit is_digit(logic [7:0] b);
            return (b >= CHAR_0) && (b <= CHAR_9);
        endfunction

        function void start_trailer();
            phase     = PH_TRAIL;
            trail_pos = 0;
            rx_sum    = '0;
        endfunction

        // Advance the parser by one byte and queue the item it produces
        function void note_byte(logic [7:0] b);
            result_t want;
            bit      fmt_err;
            int      v;
            want         = '0;
            want.out_byte = b;
            want.region  = RG_OUT;
            want.status  = ST_BUSY;
            fmt_err      = 1'b0;
            case (phase)
                PH_HUNT:
                begin
                    if (b == marker_text[marker_pos])
                    begin
                        marker_pos++;
                        if (marker_pos == MARKER_LEN)
                        begin
                            want.start_flag = 1'b1;
                            want.region     = RG_BEGIN;
                            phase           = PH_BEGIN;
                            run_sum         = MARKER_SUM;
                            len_acc         = '0;
                            marker_pos      = 0;
                        end
                    end
                    else
                        marker_pos = (b == CHAR_8) ? 1 : 0;
                end
                PH_BEGIN:
                begin
                    want.region = RG_BEGIN;
                    run_sum += b;
                    if (b == SOH_BYTE)
                        phase = PH_TAG;
                end
                PH_TAG:
                begin
                    want.region = RG_LEN;
                    run_sum += b;
                    if (b != CHAR_9)
                        fmt_err = 1'b1;
                    else
                        phase = PH_EQ;
                end
                PH_EQ:
                begin
                    want.region = RG_LEN;
                    run_sum += b;
                    if (b != CHAR_EQ)
                        fmt_err = 1'b1;
                    else
                    begin
                        phase      = PH_LEN;
                        len_acc    = '0;
                        have_digit = 1'b0;
                    end
                end
                PH_LEN:
                begin
                    want.region = RG_LEN;
                    run_sum += b;
                    if (b == SOH_BYTE)
                    begin
                        if (!have_digit)
                            fmt_err = 1'b1;
                        else
                        begin
                            have_digit = 1'b0;
                            body_left  = len_acc;
                            if (body_left == 0)
                                start_trailer();
                            else
                                phase = PH_BODY;
                        end
                    end
                    else if (is_digit(b))
                    begin
                        v = len_acc * 10 + (b - CHAR_0);
                        if (v > max_len)
                            fmt_err = 1'b1;
                        else
                        begin
                            len_acc    = 16'(v);
                            have_digit = 1'b1;
                        end
                    end
                    else
                        fmt_err = 1'b1;
                end
                PH_BODY:
                begin
                    want.region = RG_BODY;
                    run_sum += b;
                    if (body_left > 0)
                        body_left--;
                    if (body_left == 0)
                        start_trailer();
                end
                PH_TRAIL:
                begin
                    want.region = RG_TRAIL;
                    if (trail_pos < 3)
                    begin
                        if (b != trailer_text[trail_pos])
                            fmt_err = 1'b1;
                        else
                            trail_pos++;
                    end
                    else if (trail_pos < 6)
                    begin
                        if (!is_digit(b))
                            fmt_err = 1'b1;
                        else
                        begin
                            rx_sum = 10'(rx_sum * 10 + (b - CHAR_0));
                            trail_pos++;
                        end
                    end
                    else
                    begin
                        // closing byte, any value
                        want.end_flag = 1'b1;
                        want.status   = (rx_sum == {2'b00, run_sum}) ? ST_GOOD : ST_BAD;
                        phase         = PH_HUNT;
                        marker_pos    = 0;
                        trail_pos     = 0;
                    end
                end
                default:
                    phase = PH_HUNT;
            endcase

            // abort: back to hunting, an offending '8' opens a new marker
            if (fmt_err)
            begin
                want.end_flag = 1'b1;
                want.status   = ST_FMT;
                phase         = PH_HUNT;
                marker_pos    = (b == CHAR_8) ? 1 : 0;
                trail_pos     = 0;
            end
            if (want.end_flag)
            begin
                want.msg_len      = len_acc;
                want.computed_sum = run_sum;
            end
            expected_items.insert(expected_items.size(), want);
        endfunction

        function void report(string field, logic [15:0] want, logic [15:0] got);
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            error_count++;
        endfunction

        function void check_item(result_t got);
            result_t want;
            if (expected_items.size() == 0)
            begin
                $error("output item with no byte pending: out_byte %02h", got.out_byte);
                error_count++;
                return;
            end
            want = expected_items.pop_front();
            if (got.out_byte !== want.out_byte)
                report("out_byte", want.out_byte, got.out_byte);
            if (got.start_flag !== want.start_flag)
                report("start_flag", want.start_flag, got.start_flag);
            if (got.region !== want.region)
                report("region", want.region, got.region);
            if (got.end_flag !== want.end_flag)
                report("end_flag", want.end_flag, got.end_flag);
            if (got.status !== want.status)
                report("status", want.status, got.status);
            if (got.msg_len !== want.msg_len)
                report("msg_len", want.msg_len, got.msg_len);
            if (got.computed_sum !== want.computed_sum)
                report("computed_sum", want.computed_sum, got.computed_sum);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;   // [7:0] data_byte
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [7:0] out_byte, [9:8] status, [25:10] msg_len, [33:26] computed_sum
    logic [TDATA_W-1:0]   m_tdata;
    logic [TUSER_W-1:0]   m_tuser;        // [0] start_flag, [3:1] region
    logic                 m_tlast;        // end_flag
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [15:0]          cfg_data = '0;  // max_body_length

    deframer_scoreboard   sb = new();
    int                   tx_gap_pct = 0;
    int                   rx_stall_pct = 0;
    logic                 rx_hold = 1'b0;
    bit                   holdoff_go = 1'b0;
    int                   cycle_count = 0;
    int                   byte_count = 0;
    int                   cur_max_len = 65535;
    logic [7:0]           frame_bytes[$];
    logic [7:0]           frame_sum = '0;

    fix_message_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off
    always @(negedge clk)
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);

    initial
    begin
        wait (holdoff_go);
        @(negedge clk);
        rx_hold <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        rx_hold <= 1'b0;
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_item(result_t'({m_tdata[7:0], m_tuser[0], m_tuser[3:1], m_tlast,
                                     m_tdata[9:8], m_tdata[25:10], m_tdata[33:26]}));
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(b);
        byte_count++;
    endtask

    task automatic send_frame();
        while (frame_bytes.size() != 0)
            send_byte(frame_bytes.pop_front());
    endtask

    // Register write, only once every pending item has come out
    task automatic write_max_len(input logic [15:0] v);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_max_len(v);
        cur_max_len = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b);
        frame_bytes.insert(frame_bytes.size(), b);
        frame_sum = frame_sum + b;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // Marker plus empty begin string, up to where the length tag belongs
    task automatic broken_header();
        push_text("8=FIX");
        push_byte(SOH_BYTE);
    endtask

    // Whole message; body_n may differ from len when the length is meant to fail
    task automatic build_frame(input int len, input int body_n, input int begin_n,
                               input int zeros, input bit sum_ok);
        logic [9:0] claimed;
        frame_sum = '0;
        push_text("8=FIX");
        repeat (begin_n) push_byte(8'($urandom_range(2, 255)));
        push_byte(SOH_BYTE);
        push_text("9=");
        repeat (zeros) push_byte(CHAR_0);
        push_text($sformatf("%0d", len));
        push_byte(SOH_BYTE);
        repeat (body_n) push_byte(8'($urandom_range(255)));
        if (sum_ok)
            claimed = {2'b00, frame_sum};
        else if ($urandom_range(1) == 0)
            claimed = {2'b00, frame_sum ^ (8'd1 << $urandom_range(7))};
        else
            claimed = 10'($urandom_range(256, 999));
        push_text("10=");
        push_text($sformatf("%03d", claimed));
        push_byte(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : SOH_BYTE);
    endtask

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(9))
            0: return CHAR_8;
            1: return CHAR_EQ;
            2: return CHAR_F;
            3: return CHAR_I;
            4: return CHAR_X;
            5: return CHAR_9;
            6: return CHAR_1;
            7: return SOH_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Mostly short bodies, sometimes the limit itself or just past it
    function automatic int pick_length();
        int r;
        int cap;
        r = $urandom_range(99);
        if (r < 8)
            return cur_max_len + 1 + $urandom_range(0, 30);
        if (r < 16 && cur_max_len <= 300)
            return cur_max_len;
        cap = (r < 19) ? 250 : 24;
        if (cap > cur_max_len)
            cap = cur_max_len;
        return $urandom_range(0, cap);
    endfunction

    task automatic directed_cases();
        // field extremes and a restarted partial marker
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text("88=FI8=FIX");
        push_byte(SOH_BYTE);
        push_text("9=0");
        push_byte(SOH_BYTE);
        push_text("10=000");
        push_byte(SOH_BYTE);
        send_frame();
        // empty begin string, zero length, good sum; then bad sum
        build_frame(0, 0, 0, 0, 1'b1);
        build_frame(3, 3, 4, 0, 1'b0);
        // leading zeros in the length, odd closing byte
        build_frame(2, 2, 1, 2, 1'b1);
        frame_bytes[frame_bytes.size() - 1] = 8'hFF;
        send_frame();
        // missing length tag, the offending '8' opens the next marker
        broken_header();
        build_frame(1, 1, 2, 0, 1'b1);
        // missing '=' after the tag
        broken_header();
        push_text("9x");
        // empty length
        broken_header();
        push_text("9=");
        push_byte(SOH_BYTE);
        // non-digit in the length
        broken_header();
        push_text("9=1a");
        // length past the limit and past 16 bits
        broken_header();
        push_text("9=65536");
        // bad trailer tag
        broken_header();
        push_text("9=0");
        push_byte(SOH_BYTE);
        push_text("1x");
        // non-digit among the checksum digits
        broken_header();
        push_text("9=0");
        push_byte(SOH_BYTE);
        push_text("10=1z");
        // received checksum beyond one byte
        broken_header();
        push_text("9=0");
        push_byte(SOH_BYTE);
        push_text("10=999");
        push_byte(8'h00);
        send_frame();
    endtask

    // Mostly well-formed messages, some with one damaged byte, some line noise
    task automatic random_traffic(input int n_bytes);
        int stop_at;
        int r;
        int len;
        stop_at = byte_count + n_bytes;
        while (byte_count < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 85)
            begin
                len = pick_length();
                build_frame(len, (len > cur_max_len) ? $urandom_range(0, 8) : len,
                            $urandom_range(0, 6),
                            ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0,
                            $urandom_range(99) < 75);
                if (r >= 70)
                    frame_bytes[$urandom_range(frame_bytes.size() - 1)] =
                        8'($urandom_range(255));
            end
            else
                repeat ($urandom_range(1, 20)) push_byte(noise_byte());
            send_frame();
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // sender idles a little, receiver a lot
        tx_gap_pct   = 14;
        rx_stall_pct = 59;
        directed_cases();
        write_max_len(16'd0);
        random_traffic(80);
        write_max_len(16'd12);
        random_traffic(200);

        // the other way round
        tx_gap_pct   = 59;
        rx_stall_pct = 14;
        write_max_len(16'd1);
        random_traffic(100);
        write_max_len(16'hFFFF);
        random_traffic(220);

        // full rate, with one long receiver hold-off
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        write_max_len(16'd200);
        holdoff_go = 1'b1;
        random_traffic(250);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/fmd_pkg.sv
rtl/core/fmd_parser.sv
rtl/core/fix_message_deframer.sv
rtl/core/fmd_checker.sv
bench/tb_fix_message_deframer.sv
